### rtl/core/line_pixel_rasterizer_defines.svh
// ----------------------------------------------------------------------------
// Line pixel rasterizer assertion macros
// Shared property forms for the concurrent checks of the rasterizer.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_RASTERIZER_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lpr_pkg.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer package
// Widths, codes, queue item type and helpers shared by the rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int COLOR_BITS  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam logic [1:0] PH_LOOP  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   wide_coord_t;
  typedef logic        [COORD_BITS-1:0] delta_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic        [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    logic   req_type;
    logic   steep;
    logic   minor_step_neg;
    coord_t major_pos;
    coord_t major_end;
    coord_t minor_pos;
    delta_t delta_major;
    delta_t delta_minor;
    err_t   error_term;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t color;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] phase;
    logic       emit_last;
  } back_stat_t;

  function automatic delta_t abs_delta(wide_coord_t v);
    wide_coord_t m;
    m = v[COORD_BITS] ? -v : v;
    return m[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/lpr_if.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer channels
// Valid/ready channels for command items and pixel items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpr_in_if;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  lpr_pkg::coord_t       start_x;
  lpr_pkg::coord_t       start_y;
  lpr_pkg::coord_t       end_x;
  lpr_pkg::coord_t       end_y;
  lpr_pkg::color_t       color;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, color,
                  input ready);
  modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, color,
                  output ready);
endinterface

interface lpr_out_if;
  logic                  valid;
  logic                  ready;
  lpr_pkg::coord_t       pixel_x;
  lpr_pkg::coord_t       pixel_y;
  lpr_pkg::color_t       pixel_color;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

`default_nettype wire

### rtl/core/line_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer
// Bresenham line rasterizer: a load item sets up a line, each step item on an
// active line emits one pixel, loop pixels first, then start and end points.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle, load or step, while the queue has room,
// and each step on an active line gives one pixel item, so pixels leave at
// one per cycle when the sink keeps ready high. A step item passes the front
// end into the two-entry command queue, then the stepper, whose add and
// compare on the error term updates the line and fills the output register.
// Input ready drops only while the queue is full, which happens when the
// output stays stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "line_pixel_rasterizer_defines.svh"

module line_pixel_rasterizer (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lpr_in_if.sink      in_ch,
  lpr_out_if.source   out_ch
);

  logic                  q_push, q_full, q_valid, q_pop;
  lpr_pkg::cmd_t         q_in_cmd, q_head_cmd;
  lpr_pkg::back_stat_t   stat;

  lpr_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_in_cmd)
  );

  lpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head_cmd)
  );

  lpr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_head_cmd),
    .q_pop   (q_pop),
    .stat    (stat),
    .out_ch  (out_ch)
  );

  `LPR_ASSERT_NOW(a_pop_needs_item, q_pop, q_valid, "queue popped while empty")
  `LPR_ASSERT_NOW(a_idle_phase, !stat.busy, stat.phase == lpr_pkg::PH_LOOP, "idle with phase set")
  `LPR_ASSERT_NEXT(a_last_ends_line, stat.emit_last, !stat.busy && out_ch.valid && out_ch.last, "end point did not close the line")

endmodule

`default_nettype wire

### rtl/core/lpr_front.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer front end
// Accepts command items and works out octant, ordering and error setup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpr_front (
  lpr_in_if.sink          in_ch,
  input  wire logic       q_full,
  output logic            q_push,
  output lpr_pkg::cmd_t   q_cmd
);

  lpr_pkg::wide_coord_t dx, dy, dmaj, dmin;
  lpr_pkg::delta_t      adx, ady, adin;
  logic                 steep, swap;
  lpr_pkg::err_t        err0;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    dx    = lpr_pkg::wide_coord_t'(in_ch.end_x) - lpr_pkg::wide_coord_t'(in_ch.start_x);
    dy    = lpr_pkg::wide_coord_t'(in_ch.end_y) - lpr_pkg::wide_coord_t'(in_ch.start_y);
    adx   = lpr_pkg::abs_delta(dx);
    ady   = lpr_pkg::abs_delta(dy);
    steep = !(ady < adx);
    dmaj  = steep ? dy : dx;
    dmin  = steep ? dx : dy;
    swap  = dmaj[lpr_pkg::COORD_BITS];
    adin  = steep ? adx : ady;
    err0  = lpr_pkg::err_t'({2'b00, adin, 1'b0})
          - lpr_pkg::err_t'({3'b000, (steep ? ady : adx)});

    q_cmd.req_type       = in_ch.req_type;
    q_cmd.steep          = steep;
    q_cmd.minor_step_neg = swap ? (!dmin[lpr_pkg::COORD_BITS] && (dmin != '0))
                                : dmin[lpr_pkg::COORD_BITS];
    if (steep) begin
      q_cmd.major_pos = swap ? in_ch.end_y   : in_ch.start_y;
      q_cmd.major_end = swap ? in_ch.start_y : in_ch.end_y;
      q_cmd.minor_pos = swap ? in_ch.end_x   : in_ch.start_x;
    end else begin
      q_cmd.major_pos = swap ? in_ch.end_x   : in_ch.start_x;
      q_cmd.major_end = swap ? in_ch.start_x : in_ch.end_x;
      q_cmd.minor_pos = swap ? in_ch.end_y   : in_ch.start_y;
    end
    q_cmd.delta_major = steep ? ady : adx;
    q_cmd.delta_minor = adin;
    q_cmd.error_term  = err0;
    q_cmd.start_x     = in_ch.start_x;
    q_cmd.start_y     = in_ch.start_y;
    q_cmd.end_x       = in_ch.end_x;
    q_cmd.end_y       = in_ch.end_y;
    q_cmd.color       = in_ch.color;
  end

endmodule

`default_nettype wire

### rtl/core/lpr_queue.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer command queue
// Short register queue between the front end and the pixel stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lpr_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output logic                full,
  output logic                head_valid,
  output lpr_pkg::cmd_t       head_cmd
);

  lpr_pkg::cmd_t                    entry_r [lpr_pkg::QUEUE_DEPTH];
  logic [lpr_pkg::QPTR_BITS-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lpr_pkg::QPTR_BITS-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lpr_pkg::QCNT_BITS-1:0]    count_r, count_nxt;

  assign full       = (count_r == lpr_pkg::QCNT_BITS'(lpr_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lpr_back.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer stepper
// Holds the active line and emits one pixel per step item on an active line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpr_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire lpr_pkg::cmd_t    q_cmd,
  output logic                  q_pop,
  output lpr_pkg::back_stat_t   stat,
  lpr_out_if.source             out_ch
);

  logic                busy_r, busy_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic                steep_r, steep_nxt;
  logic                neg_r, neg_nxt;
  lpr_pkg::coord_t     major_r, major_nxt;
  lpr_pkg::coord_t     major_end_r, major_end_nxt;
  lpr_pkg::coord_t     minor_r, minor_nxt;
  lpr_pkg::delta_t     dmaj_r, dmaj_nxt;
  lpr_pkg::delta_t     dmin_r, dmin_nxt;
  lpr_pkg::err_t       err_r, err_nxt;
  lpr_pkg::coord_t     sx_r, sx_nxt, sy_r, sy_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  lpr_pkg::color_t     color_r, color_nxt;

  logic                ovalid_r, ovalid_nxt;
  lpr_pkg::coord_t     ox_r, ox_nxt, oy_r, oy_nxt;
  lpr_pkg::color_t     ocolor_r, ocolor_nxt;
  logic                olast_r, olast_nxt;

  logic                out_free, do_load, do_step, emit_last;
  lpr_pkg::coord_t     major_inc;

  assign out_free = !ovalid_r || out_ch.ready;
  assign q_pop    = q_valid && ((q_cmd.req_type == lpr_pkg::REQ_LOAD) || out_free);
  assign do_load  = q_pop && (q_cmd.req_type == lpr_pkg::REQ_LOAD);
  assign do_step  = q_pop && (q_cmd.req_type == lpr_pkg::REQ_STEP) && busy_r;
  assign major_inc = major_r + 1'b1;

  assign emit_last      = do_step && (phase_r == lpr_pkg::PH_END);
  assign stat.busy      = busy_r;
  assign stat.phase     = phase_r;
  assign stat.emit_last = emit_last;

  assign out_ch.valid       = ovalid_r;
  assign out_ch.pixel_x     = ox_r;
  assign out_ch.pixel_y     = oy_r;
  assign out_ch.pixel_color = ocolor_r;
  assign out_ch.last        = olast_r;

  always_comb begin
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    steep_nxt     = steep_r;
    neg_nxt       = neg_r;
    major_nxt     = major_r;
    major_end_nxt = major_end_r;
    minor_nxt     = minor_r;
    dmaj_nxt      = dmaj_r;
    dmin_nxt      = dmin_r;
    err_nxt       = err_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    color_nxt     = color_r;
    ovalid_nxt    = ovalid_r && !out_ch.ready;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    ocolor_nxt    = ocolor_r;
    olast_nxt     = olast_r;

    if (do_load) begin
      busy_nxt      = 1'b1;
      phase_nxt     = (q_cmd.delta_major != '0) ? lpr_pkg::PH_LOOP : lpr_pkg::PH_START;
      steep_nxt     = q_cmd.steep;
      neg_nxt       = q_cmd.minor_step_neg;
      major_nxt     = q_cmd.major_pos;
      major_end_nxt = q_cmd.major_end;
      minor_nxt     = q_cmd.minor_pos;
      dmaj_nxt      = q_cmd.delta_major;
      dmin_nxt      = q_cmd.delta_minor;
      err_nxt       = q_cmd.error_term;
      sx_nxt        = q_cmd.start_x;
      sy_nxt        = q_cmd.start_y;
      ex_nxt        = q_cmd.end_x;
      ey_nxt        = q_cmd.end_y;
      color_nxt     = q_cmd.color;
    end else if (do_step) begin
      ovalid_nxt = 1'b1;
      ocolor_nxt = color_r;
      olast_nxt  = 1'b0;
      case (phase_r)
        lpr_pkg::PH_LOOP: begin
          ox_nxt = steep_r ? minor_r : major_r;
          oy_nxt = steep_r ? major_r : minor_r;
          if (err_r > 0) begin
            minor_nxt = neg_r ? minor_r - 1'b1 : minor_r + 1'b1;
            err_nxt   = err_r + lpr_pkg::err_t'({2'b00, dmin_r, 1'b0})
                      - lpr_pkg::err_t'({2'b00, dmaj_r, 1'b0});
          end else begin
            err_nxt   = err_r + lpr_pkg::err_t'({2'b00, dmin_r, 1'b0});
          end
          major_nxt = major_inc;
          if (major_inc == major_end_r) begin
            phase_nxt = lpr_pkg::PH_START;
          end
        end
        lpr_pkg::PH_START: begin
          ox_nxt    = sx_r;
          oy_nxt    = sy_r;
          phase_nxt = lpr_pkg::PH_END;
        end
        default: begin
          ox_nxt    = ex_r;
          oy_nxt    = ey_r;
          olast_nxt = 1'b1;
          busy_nxt  = 1'b0;
          phase_nxt = lpr_pkg::PH_LOOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      phase_r  <= lpr_pkg::PH_LOOP;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steep_r     <= steep_nxt;
    neg_r       <= neg_nxt;
    major_r     <= major_nxt;
    major_end_r <= major_end_nxt;
    minor_r     <= minor_nxt;
    dmaj_r      <= dmaj_nxt;
    dmin_r      <= dmin_nxt;
    err_r       <= err_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    color_r     <= color_nxt;
    ox_r        <= ox_nxt;
    oy_r        <= oy_nxt;
    ocolor_r    <= ocolor_nxt;
    olast_r     <= olast_nxt;
  end

endmodule

`default_nettype wire

### verif/line_pixel_rasterizer_test.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer testbench
// Drives load and step items through the command channel and checks every
// pixel item against a cycle-free Bresenham predictor or a typed pixel. A
// directed table with endpoint extremes, reversed, steep, diagonal and
// single-point lines runs first, then random lines with random idles on both
// channels, one long output stall and one long line run into the top corner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pixel_rasterizer_test;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int RANDOM_ITEMS     = 1000;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 20;
  localparam int DIRECTED_ROWS    = 25;
  localparam int REPORT_LIMIT     = 10;

  typedef struct packed {
    logic            req_type;
    lpr_pkg::coord_t start_x;
    lpr_pkg::coord_t start_y;
    lpr_pkg::coord_t end_x;
    lpr_pkg::coord_t end_y;
    lpr_pkg::color_t color;
  } cmd_item_t;

  typedef struct packed {
    lpr_pkg::coord_t x;
    lpr_pkg::coord_t y;
    lpr_pkg::color_t color;
    logic            last;
  } pixel_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_PIXEL
  } row_check_t;

  typedef struct packed {
    cmd_item_t  cmd;
    row_check_t chk;
    pixel_t     px;
  } directed_row_t;

  bit   clk = 1'b0;
  logic rst_n;

  lpr_in_if  in_ch ();
  lpr_out_if out_ch ();

  line_pixel_rasterizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // line tracker state
  bit              tr_busy;
  logic [1:0]      tr_phase;
  bit              tr_steep;
  int              tr_major;
  int              tr_major_stop;
  int              tr_minor;
  bit              tr_minor_down;
  int              tr_dmajor;
  int              tr_dminor;
  int              tr_err;
  int              tr_pts [4];
  lpr_pkg::color_t tr_color;

  pixel_t        pending_pixels [$];
  directed_row_t directed_rows [DIRECTED_ROWS];

  int cycle_count;
  int mismatches;
  int loads_sent;
  int steps_sent;
  int pixels_checked;
  bit sink_hold;
  bit sender_calm;

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int line_span(cmd_item_t c);
    int dx, dy;
    dx = mag(int'(c.end_x) - int'(c.start_x));
    dy = mag(int'(c.end_y) - int'(c.start_y));
    return ((dx > dy) ? dx : dy) + 2;
  endfunction

  function automatic directed_row_t row(logic rt, int sx, int sy, int ex, int ey,
                                        lpr_pkg::color_t col, row_check_t chk,
                                        int px, int py, logic lst);
    directed_row_t r;
    r.cmd.req_type = rt;
    r.cmd.start_x  = lpr_pkg::coord_t'(sx);
    r.cmd.start_y  = lpr_pkg::coord_t'(sy);
    r.cmd.end_x    = lpr_pkg::coord_t'(ex);
    r.cmd.end_y    = lpr_pkg::coord_t'(ey);
    r.cmd.color    = col;
    r.chk          = chk;
    r.px.x         = lpr_pkg::coord_t'(px);
    r.px.y         = lpr_pkg::coord_t'(py);
    r.px.color     = col;
    r.px.last      = lst;
    return r;
  endfunction

  function automatic cmd_item_t random_cmd(logic rt);
    cmd_item_t c;
    c.req_type = rt;
    c.start_x  = lpr_pkg::coord_t'($urandom);
    c.start_y  = lpr_pkg::coord_t'($urandom);
    c.end_x    = lpr_pkg::coord_t'($urandom);
    c.end_y    = lpr_pkg::coord_t'($urandom);
    c.color    = $urandom;
    return c;
  endfunction

  function automatic cmd_item_t short_line();
    cmd_item_t c;
    int cx, cy;
    cx = int'($urandom_range(0, 4063)) - 2032;
    cy = int'($urandom_range(0, 4063)) - 2032;
    c.req_type = lpr_pkg::REQ_LOAD;
    c.start_x  = lpr_pkg::coord_t'(cx);
    c.start_y  = lpr_pkg::coord_t'(cy);
    c.end_x    = lpr_pkg::coord_t'(cx + int'($urandom_range(0, 32)) - 16);
    c.end_y    = lpr_pkg::coord_t'(cy + int'($urandom_range(0, 32)) - 16);
    c.color    = $urandom;
    return c;
  endfunction

  task automatic rasterize(input cmd_item_t c, output bit emits, output pixel_t px);
    int a0, b0, a1, b1, swap, dminor;
    emits = 1'b0;
    px    = '0;
    if (c.req_type == lpr_pkg::REQ_LOAD) begin
      tr_pts[0] = c.start_x;
      tr_pts[1] = c.start_y;
      tr_pts[2] = c.end_x;
      tr_pts[3] = c.end_y;
      tr_color  = c.color;
      tr_steep  = !(mag(tr_pts[3] - tr_pts[1]) < mag(tr_pts[2] - tr_pts[0]));
      if (tr_steep) begin
        a0 = tr_pts[1]; b0 = tr_pts[0]; a1 = tr_pts[3]; b1 = tr_pts[2];
      end else begin
        a0 = tr_pts[0]; b0 = tr_pts[1]; a1 = tr_pts[2]; b1 = tr_pts[3];
      end
      if (a0 > a1) begin
        swap = a0; a0 = a1; a1 = swap;
        swap = b0; b0 = b1; b1 = swap;
      end
      dminor        = b1 - b0;
      tr_dmajor     = a1 - a0;
      tr_minor_down = (dminor < 0);
      tr_dminor     = mag(dminor);
      tr_err        = 2 * tr_dminor - tr_dmajor;
      tr_major      = a0;
      tr_major_stop = a1;
      tr_minor      = b0;
      tr_busy       = 1'b1;
      tr_phase      = (a0 < a1) ? lpr_pkg::PH_LOOP : lpr_pkg::PH_START;
    end else if (tr_busy) begin
      emits    = 1'b1;
      px.color = tr_color;
      case (tr_phase)
        lpr_pkg::PH_LOOP: begin
          px.x    = lpr_pkg::coord_t'(tr_steep ? tr_minor : tr_major);
          px.y    = lpr_pkg::coord_t'(tr_steep ? tr_major : tr_minor);
          px.last = 1'b0;
          if (tr_err > 0) begin
            tr_minor += tr_minor_down ? -1 : 1;
            tr_err   += 2 * (tr_dminor - tr_dmajor);
          end else begin
            tr_err += 2 * tr_dminor;
          end
          tr_major++;
          if (!(tr_major < tr_major_stop)) tr_phase = lpr_pkg::PH_START;
        end
        lpr_pkg::PH_START: begin
          px.x     = lpr_pkg::coord_t'(tr_pts[0]);
          px.y     = lpr_pkg::coord_t'(tr_pts[1]);
          px.last  = 1'b0;
          tr_phase = lpr_pkg::PH_END;
        end
        default: begin
          px.x     = lpr_pkg::coord_t'(tr_pts[2]);
          px.y     = lpr_pkg::coord_t'(tr_pts[3]);
          px.last  = 1'b1;
          tr_busy  = 1'b0;
          tr_phase = lpr_pkg::PH_LOOP;
        end
      endcase
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  task automatic offer(input cmd_item_t c, input row_check_t chk, input pixel_t typed);
    bit     emits;
    pixel_t px;
    int     gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= c.req_type;
    in_ch.start_x  <= c.start_x;
    in_ch.start_y  <= c.start_y;
    in_ch.end_x    <= c.end_x;
    in_ch.end_y    <= c.end_y;
    in_ch.color    <= c.color;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rasterize(c, emits, px);
    case (chk)
      CHK_MODEL: if (emits) pending_pixels.push_back(px);
      CHK_PIXEL: pending_pixels.push_back(typed);
      default: ;
    endcase
    if (c.req_type == lpr_pkg::REQ_LOAD) loads_sent++;
    else steps_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // output checker
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%b",
                                out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color,
                                out_ch.last));
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.pixel_x !== want.x || out_ch.pixel_y !== want.y ||
            out_ch.pixel_color !== want.color || out_ch.last !== want.last) begin
          flag_mismatch($sformatf(
            "pixel exp x=%0d y=%0d color=%h last=%b got x=%0d y=%0d color=%h last=%b",
            want.x, want.y, want.color, want.last, out_ch.pixel_x, out_ch.pixel_y,
            out_ch.pixel_color, out_ch.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
               pending_pixels.size());
      $display("line_pixel_rasterizer_test NOT OK");
      $finish;
    end
  end

  // pixel sink: random ready, plus one long hold on request
  initial begin
    int r;
    int run;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ch.ready <= 1'b1;
          run = $urandom_range(1, 30);
        end else if (r < 65) begin
          out_ch.ready <= 1'b1;
          run = $urandom_range(100, 300);
        end else if (r < 92) begin
          out_ch.ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          out_ch.ready <= 1'b0;
          run = $urandom_range(5, 20);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    int        i;
    int        r;
    int        steps;
    int        needed;
    int        n_random;
    bit        long_done;
    bit        hold_done;
    bit        pause_done;
    cmd_item_t ln;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= lpr_pkg::REQ_STEP;
    in_ch.start_x  <= '0;
    in_ch.start_y  <= '0;
    in_ch.end_x    <= '0;
    in_ch.end_y    <= '0;
    in_ch.color    <= '0;

    directed_rows[0]  = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0, CHK_NONE, 0, 0, 0);
    directed_rows[1]  = row(lpr_pkg::REQ_LOAD, 0, 0, 0, 0, 32'hFFFF_FFFF, CHK_NONE,
                            0, 0, 0);
    directed_rows[2]  = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'hFFFF_FFFF, CHK_PIXEL,
                            0, 0, 0);
    directed_rows[3]  = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'hFFFF_FFFF, CHK_PIXEL,
                            0, 0, 1);
    directed_rows[4]  = row(lpr_pkg::REQ_STEP, 2047, 2047, 2047, 2047, 32'hFFFF_FFFF,
                            CHK_NONE, 0, 0, 0);
    directed_rows[5]  = row(lpr_pkg::REQ_LOAD, -2048, -2048, 2047, 2047, 32'h0,
                            CHK_NONE, 0, 0, 0);
    directed_rows[6]  = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0, CHK_MODEL, 0, 0, 0);
    directed_rows[7]  = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0, CHK_MODEL, 0, 0, 0);
    directed_rows[8]  = row(lpr_pkg::REQ_LOAD, 2047, -2048, -2048, 0, 32'h8000_0001,
                            CHK_NONE, 0, 0, 0);
    directed_rows[9]  = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h8000_0001, CHK_MODEL,
                            0, 0, 0);
    directed_rows[10] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h8000_0001, CHK_MODEL,
                            0, 0, 0);
    directed_rows[11] = row(lpr_pkg::REQ_LOAD, 5, 5, 2, 8, 32'h1234_5678, CHK_NONE,
                            0, 0, 0);
    directed_rows[12] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h1234_5678, CHK_MODEL,
                            0, 0, 0);
    directed_rows[13] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h1234_5678, CHK_MODEL,
                            0, 0, 0);
    directed_rows[14] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h1234_5678, CHK_MODEL,
                            0, 0, 0);
    directed_rows[15] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h1234_5678, CHK_PIXEL,
                            5, 5, 0);
    directed_rows[16] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h1234_5678, CHK_PIXEL,
                            2, 8, 1);
    directed_rows[17] = row(lpr_pkg::REQ_STEP, -1, -1, -1, -1, 32'h1234_5678, CHK_NONE,
                            0, 0, 0);
    directed_rows[18] = row(lpr_pkg::REQ_LOAD, 10, 1, 6, 3, 32'hA5A5_A5A5, CHK_NONE,
                            0, 0, 0);
    directed_rows[19] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'hA5A5_A5A5, CHK_MODEL,
                            0, 0, 0);
    directed_rows[20] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'hA5A5_A5A5, CHK_MODEL,
                            0, 0, 0);
    directed_rows[21] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'hA5A5_A5A5, CHK_MODEL,
                            0, 0, 0);
    directed_rows[22] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'hA5A5_A5A5, CHK_MODEL,
                            0, 0, 0);
    directed_rows[23] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'hA5A5_A5A5, CHK_PIXEL,
                            10, 1, 0);
    directed_rows[24] = row(lpr_pkg::REQ_STEP, 0, 0, 0, 0, 32'hA5A5_A5A5, CHK_PIXEL,
                            6, 3, 1);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      offer(directed_rows[i].cmd, directed_rows[i].chk, directed_rows[i].px);
    end
    wait_drained();

    n_random   = 0;
    long_done  = 1'b0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (n_random < RANDOM_ITEMS) begin
      sender_calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        offer(random_cmd(logic'($urandom_range(0, 1))), CHK_MODEL, '0);
        n_random++;
      end else begin
        if (!long_done && n_random >= RANDOM_ITEMS / 2) begin
          // run one long line into the top corner to its end
          ln         = random_cmd(lpr_pkg::REQ_LOAD);
          ln.start_x = lpr_pkg::coord_t'(2047 - int'($urandom_range(100, 200)));
          ln.start_y = lpr_pkg::coord_t'(2047 - int'($urandom_range(100, 200)));
          ln.end_x   = lpr_pkg::coord_t'(2047);
          ln.end_y   = lpr_pkg::coord_t'(2047);
          steps      = line_span(ln);
          long_done  = 1'b1;
        end else if (r < 14) begin
          ln    = random_cmd(lpr_pkg::REQ_LOAD);
          steps = $urandom_range(1, 40);
        end else begin
          ln     = short_line();
          needed = line_span(ln);
          if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, needed - 1);
          else steps = needed + $urandom_range(0, 2);
        end
        offer(ln, CHK_MODEL, '0);
        n_random++;
        repeat (steps) begin
          offer(random_cmd(lpr_pkg::REQ_STEP), CHK_MODEL, '0);
          n_random++;
        end
      end
      if (!hold_done && n_random >= 300) begin
        sink_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && n_random >= 700) begin
        wait_drained();
        pause_done = 1'b1;
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += pending_pixels.size();

    $display("covered %0d line loads and %0d step items, %0d pixels checked, %0d failures",
             loads_sent, steps_sent, pixels_checked, mismatches);
    $display("including endpoint extremes, a long corner line and a %0d-cycle output stall",
             SINK_HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("line_pixel_rasterizer_test OK");
    end else begin
      $display("line_pixel_rasterizer_test NOT OK");
    end
    $finish;
  end

endmodule
